>>> sv/owbm_pkg.sv
// Package for the single-wire bus master core.
// Holds item types, function codes, register indexes and configuration types.
// No dependencies.
package owbm_pkg;

	localparam int unsigned TimeW  = 10;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [2:0] FN_TICK    = 3'd0;
	localparam logic [2:0] FN_RESET   = 3'd1;
	localparam logic [2:0] FN_WR_BYTE = 3'd2;
	localparam logic [2:0] FN_RD_BYTE = 3'd3;
	localparam logic [2:0] FN_WR_BIT  = 3'd4;
	localparam logic [2:0] FN_RD_BIT  = 3'd5;

	localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PRES_WAIT     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PRES_TIMEOUT  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_REL_TIMEOUT   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SHORT_LOW     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LONG_LOW      = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_READ_RECOVERY = 3'd7;

	typedef logic [TimeW-1:0] us_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data;
		logic       line_level;
	} owbm_cmd_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
	} owbm_res_t;

	typedef struct packed {
		us_t reset_low_us;
		us_t presence_wait_us;
		us_t presence_timeout_us;
		us_t release_timeout_us;
		us_t short_low_us;
		us_t long_low_us;
		us_t read_sample_us;
		us_t read_recovery_us;
	} owbm_cfg_t;

	// a zero-length phase still lasts one tick
	function automatic us_t min_one(input us_t v);
		return (v == '0) ? us_t'(1) : v;
	endfunction

endpackage

>>> sv/owbm_cfg_regs.sv
// Timing register file of the single-wire bus master.
// Depends on owbm_pkg.
module owbm_cfg_regs
	import owbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  us_t                cfg_data,
	output owbm_cfg_t          cfg
);

	owbm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us        <= us_t'(500);
			cfg_q.presence_wait_us    <= us_t'(15);
			cfg_q.presence_timeout_us <= us_t'(285);
			cfg_q.release_timeout_us  <= us_t'(420);
			cfg_q.short_low_us        <= us_t'(6);
			cfg_q.long_low_us         <= us_t'(65);
			cfg_q.read_sample_us      <= us_t'(1);
			cfg_q.read_recovery_us    <= us_t'(55);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESET_LOW:     cfg_q.reset_low_us        <= cfg_data;
				REG_PRES_WAIT:     cfg_q.presence_wait_us    <= cfg_data;
				REG_PRES_TIMEOUT:  cfg_q.presence_timeout_us <= cfg_data;
				REG_REL_TIMEOUT:   cfg_q.release_timeout_us  <= cfg_data;
				REG_SHORT_LOW:     cfg_q.short_low_us        <= cfg_data;
				REG_LONG_LOW:      cfg_q.long_low_us         <= cfg_data;
				REG_READ_SAMPLE:   cfg_q.read_sample_us      <= cfg_data;
				REG_READ_RECOVERY: cfg_q.read_recovery_us    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> sv/owbm_engine.sv
// Bus sequencer: input register, state update, result register.
// Depends on owbm_pkg; timing values come from owbm_cfg_regs.
module owbm_engine
	import owbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  owbm_cfg_t cfg,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  owbm_cmd_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output owbm_res_t res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_PRES_LOW, PH_PRES_HIGH,
		PH_W_LOW, PH_W_HIGH, PH_R_LOW, PH_R_WAIT, PH_R_REC
	} phase_t;

	owbm_cmd_t  cmd_s1;
	logic       vld_s1;
	owbm_res_t  res_q;
	logic       res_vld_q;
	logic       adv;

	phase_t     ph_q, ph_n;
	us_t        tm_q, tm_n;
	logic [2:0] bc_q, bc_n;
	logic [7:0] sd_q, sd_n;
	logic       bm_q, bm_n;
	logic       pf_q, pf_n;
	logic [7:0] rb_q, rb_n;
	logic       done, rej;

	us_t         tinc;
	logic [10:0] el;
	us_t         wlim;

	assign adv       = !res_vld_q || !res_stall;
	assign cmd_stall = vld_s1 && !adv;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	assign tinc = tm_q + us_t'(1);
	assign el   = {1'b0, tm_q} + 11'd1;

	always_comb begin
		ph_n = ph_q;
		tm_n = tm_q;
		bc_n = bc_q;
		sd_n = sd_q;
		bm_n = bm_q;
		pf_n = pf_q;
		rb_n = rb_q;
		done = 1'b0;
		rej  = 1'b0;
		wlim = '0;
		if (cmd_s1.func == FN_TICK) begin
			if (ph_q != PH_IDLE) begin
				unique case (ph_q)
					PH_RST_LOW: begin
						tm_n = tinc;
						if (tinc >= min_one(cfg.reset_low_us)) begin
							ph_n = PH_RST_WAIT;
							tm_n = '0;
						end
					end
					PH_RST_WAIT: begin
						tm_n = tinc;
						if (tinc >= min_one(cfg.presence_wait_us)) begin
							ph_n = PH_PRES_LOW;
							tm_n = '0;
						end
					end
					PH_PRES_LOW: begin
						if (el > {1'b0, cfg.presence_timeout_us}) begin
							pf_n = 1'b0;
							ph_n = PH_IDLE;
							tm_n = '0;
							done = 1'b1;
						end else if (!cmd_s1.line_level) begin
							ph_n = PH_PRES_HIGH;
							tm_n = '0;
						end else begin
							tm_n = el[TimeW-1:0];
						end
					end
					PH_PRES_HIGH: begin
						if (el > {1'b0, cfg.release_timeout_us}) begin
							pf_n = 1'b0;
							ph_n = PH_IDLE;
							tm_n = '0;
							done = 1'b1;
						end else if (cmd_s1.line_level) begin
							pf_n = 1'b1;
							ph_n = PH_IDLE;
							tm_n = '0;
							done = 1'b1;
						end else begin
							tm_n = el[TimeW-1:0];
						end
					end
					PH_W_LOW: begin
						wlim = sd_q[0] ? cfg.short_low_us : cfg.long_low_us;
						tm_n = tinc;
						if (tinc >= min_one(wlim)) begin
							ph_n = PH_W_HIGH;
							tm_n = '0;
						end
					end
					PH_W_HIGH: begin
						wlim = sd_q[0] ? cfg.long_low_us : cfg.short_low_us;
						tm_n = tinc;
						if (tinc >= min_one(wlim)) begin
							sd_n = {1'b0, sd_q[7:1]};
							tm_n = '0;
							if (bm_q && bc_q != 3'd7) begin
								bc_n = bc_q + 3'd1;
								ph_n = PH_W_LOW;
							end else begin
								ph_n = PH_IDLE;
								done = 1'b1;
							end
						end
					end
					PH_R_LOW: begin
						tm_n = tinc;
						if (tinc >= min_one(cfg.short_low_us)) begin
							ph_n = PH_R_WAIT;
							tm_n = '0;
						end
					end
					PH_R_WAIT: begin
						tm_n = tinc;
						if (tinc >= min_one(cfg.read_sample_us)) begin
							if (bm_q) begin
								sd_n = {cmd_s1.line_level, sd_q[7:1]};
							end else begin
								rb_n = {7'd0, cmd_s1.line_level};
							end
							ph_n = PH_R_REC;
							tm_n = '0;
						end
					end
					PH_R_REC: begin
						tm_n = tinc;
						if (tinc >= min_one(cfg.read_recovery_us)) begin
							tm_n = '0;
							if (bm_q && bc_q != 3'd7) begin
								bc_n = bc_q + 3'd1;
								ph_n = PH_R_LOW;
							end else begin
								ph_n = PH_IDLE;
								done = 1'b1;
								if (bm_q) begin
									rb_n = sd_q;
								end
							end
						end
					end
					default: begin
						ph_n = PH_IDLE;
						tm_n = '0;
					end
				endcase
			end
		end else if (cmd_s1.func <= FN_RD_BIT) begin
			if (ph_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				bc_n = '0;
				tm_n = '0;
				bm_n = (cmd_s1.func == FN_WR_BYTE) || (cmd_s1.func == FN_RD_BYTE);
				unique case (cmd_s1.func)
					FN_RESET: ph_n = PH_RST_LOW;
					FN_WR_BYTE: begin
						sd_n = cmd_s1.data;
						ph_n = PH_W_LOW;
					end
					FN_RD_BYTE: begin
						sd_n = '0;
						ph_n = PH_R_LOW;
					end
					FN_WR_BIT: begin
						sd_n = {7'd0, cmd_s1.data[0]};
						ph_n = PH_W_LOW;
					end
					default: ph_n = PH_R_LOW;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			ph_q      <= PH_IDLE;
			tm_q      <= '0;
			bc_q      <= '0;
			sd_q      <= '0;
			bm_q      <= 1'b0;
			pf_q      <= 1'b0;
			rb_q      <= '0;
		end else begin
			if (!cmd_stall) begin
				vld_s1 <= cmd_valid;
			end
			if (adv) begin
				res_vld_q <= vld_s1;
			end
			if (vld_s1 && adv) begin
				ph_q <= ph_n;
				tm_q <= tm_n;
				bc_q <= bc_n;
				sd_q <= sd_n;
				bm_q <= bm_n;
				pf_q <= pf_n;
				rb_q <= rb_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (vld_s1 && adv) begin
			res_q.drive_low <= (ph_n == PH_RST_LOW) || (ph_n == PH_W_LOW) ||
				(ph_n == PH_R_LOW);
			res_q.busy_res  <= (ph_n != PH_IDLE);
			res_q.done_res  <= done;
			res_q.presence  <= pf_n;
			res_q.read_data <= rb_n;
			res_q.rejected  <= rej;
		end
	end

	a_done_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> !(res_q.done_res && res_q.rejected))
		else $error("done and rejected in one item");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done while still busy");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.drive_low |-> res_q.busy_res)
		else $error("line driven while idle");

	a_bits_bytemode: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q != 3'd0 |-> bm_q)
		else $error("bit count moved outside byte mode");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv |=> res_vld_q)
		else $error("item lost between input and result register");

endmodule

>>> sv/one_wire_bus_master_core.sv
// Top level of the single-wire bus master core.
// Depends on owbm_pkg, owbm_cfg_regs and owbm_engine.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid/cmd_stall  | owbm_cmd_t (func, data, line_level)
//   res     | out       | res_valid/res_stall  | owbm_res_t
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while the result channel is not stalled.
// An item passes the input register, then the result register.
// arst_n clears the sequencer state and loads the default timing values.
// A stalled result holds and stops an occupied input register; cmd_stall then rises.
// cfg_ready is always high.
module one_wire_bus_master_core
	import owbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  owbm_cmd_t          cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output owbm_res_t          res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  us_t                cfg_data
);

	owbm_cfg_t cfg;

	owbm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owbm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> test/owbm_checker.sv
// Checker for the single-wire bus master core: tracks the sequencer and timing registers,
// predicts one result per accepted item and compares it with the result channel.
// Depends on owbm_pkg.
module owbm_checker
	import owbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  owbm_cmd_t          cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  owbm_res_t          res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  us_t                cfg_data,
	output int                 fails,
	output int                 pending
);

	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_PRES_LOW, SEQ_PRES_HIGH,
		SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REC
	} seq_t;

	owbm_cfg_t  timing;
	seq_t       seq;
	us_t        us_cnt;
	logic [2:0] bit_idx;
	logic [7:0] shreg;
	logic       whole_byte;
	logic       slave_seen;
	logic [7:0] last_read;
	owbm_res_t  bus_results_q[$];
	owbm_res_t  want;
	int         errs;

	function automatic void go(seq_t s);
		seq = s;
		us_cnt = '0;
	endfunction

	// count one microsecond; a zero length still takes one tick
	function automatic logic span_over(us_t lim);
		us_cnt = us_cnt + us_t'(1);
		return us_cnt >= ((lim == '0) ? us_t'(1) : lim);
	endfunction

	function automatic logic slot_over(seq_t low_state);
		if (whole_byte && bit_idx != 3'd7) begin
			bit_idx = bit_idx + 3'd1;
			go(low_state);
			return 1'b0;
		end
		go(SEQ_IDLE);
		return 1'b1;
	endfunction

	function automatic logic advance_us(logic line);
		int unsigned el;
		logic fin;
		el = 32'(us_cnt) + 32'd1;
		fin = 1'b0;
		case (seq)
		SEQ_RST_LOW: begin
			if (span_over(timing.reset_low_us))
				go(SEQ_RST_WAIT);
		end
		SEQ_RST_WAIT: begin
			if (span_over(timing.presence_wait_us))
				go(SEQ_PRES_LOW);
		end
		SEQ_PRES_LOW: begin
			if (el > 32'(timing.presence_timeout_us)) begin
				slave_seen = 1'b0;
				go(SEQ_IDLE);
				fin = 1'b1;
			end else if (!line)
				go(SEQ_PRES_HIGH);
			else
				us_cnt = us_t'(el);
		end
		SEQ_PRES_HIGH: begin
			if (el > 32'(timing.release_timeout_us)) begin
				slave_seen = 1'b0;
				go(SEQ_IDLE);
				fin = 1'b1;
			end else if (line) begin
				slave_seen = 1'b1;
				go(SEQ_IDLE);
				fin = 1'b1;
			end else
				us_cnt = us_t'(el);
		end
		SEQ_WR_LOW: begin
			if (span_over(shreg[0] ? timing.short_low_us : timing.long_low_us))
				go(SEQ_WR_HIGH);
		end
		SEQ_WR_HIGH: begin
			if (span_over(shreg[0] ? timing.long_low_us : timing.short_low_us)) begin
				shreg = shreg >> 1;
				fin = slot_over(SEQ_WR_LOW);
			end
		end
		SEQ_RD_LOW: begin
			if (span_over(timing.short_low_us))
				go(SEQ_RD_WAIT);
		end
		SEQ_RD_WAIT: begin
			if (span_over(timing.read_sample_us)) begin
				if (whole_byte)
					shreg = {line, shreg[7:1]};
				else
					last_read = {7'd0, line};
				go(SEQ_RD_REC);
			end
		end
		SEQ_RD_REC: begin
			if (span_over(timing.read_recovery_us)) begin
				fin = slot_over(SEQ_RD_LOW);
				if (fin && whole_byte)
					last_read = shreg;
			end
		end
		default: go(SEQ_IDLE);
		endcase
		return fin;
	endfunction

	function automatic owbm_res_t bus_step(owbm_cmd_t c);
		owbm_res_t r;
		logic fin;
		logic rej;
		fin = 1'b0;
		rej = 1'b0;
		if (c.func == FN_TICK) begin
			if (seq != SEQ_IDLE)
				fin = advance_us(c.line_level);
		end else if (c.func <= FN_RD_BIT) begin
			if (seq != SEQ_IDLE)
				rej = 1'b1;
			else begin
				bit_idx = '0;
				whole_byte = (c.func == FN_WR_BYTE || c.func == FN_RD_BYTE);
				case (c.func)
				FN_RESET: go(SEQ_RST_LOW);
				FN_WR_BYTE: begin
					shreg = c.data;
					go(SEQ_WR_LOW);
				end
				FN_RD_BYTE: begin
					shreg = '0;
					go(SEQ_RD_LOW);
				end
				FN_WR_BIT: begin
					shreg = {7'd0, c.data[0]};
					go(SEQ_WR_LOW);
				end
				default: go(SEQ_RD_LOW);
				endcase
			end
		end
		r.drive_low = (seq == SEQ_RST_LOW || seq == SEQ_WR_LOW || seq == SEQ_RD_LOW);
		r.busy_res  = (seq != SEQ_IDLE);
		r.done_res  = fin;
		r.presence  = slave_seen;
		r.read_data = last_read;
		r.rejected  = rej;
		return r;
	endfunction

	task automatic flag(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
		$display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = {10'd500, 10'd15, 10'd285, 10'd420, 10'd6, 10'd65, 10'd1, 10'd55};
			seq = SEQ_IDLE;
			us_cnt = '0;
			bit_idx = '0;
			shreg = '0;
			whole_byte = 1'b0;
			slave_seen = 1'b0;
			last_read = '0;
			bus_results_q.delete();
			errs = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_RESET_LOW:     timing.reset_low_us = cfg_data;
				REG_PRES_WAIT:     timing.presence_wait_us = cfg_data;
				REG_PRES_TIMEOUT:  timing.presence_timeout_us = cfg_data;
				REG_REL_TIMEOUT:   timing.release_timeout_us = cfg_data;
				REG_SHORT_LOW:     timing.short_low_us = cfg_data;
				REG_LONG_LOW:      timing.long_low_us = cfg_data;
				REG_READ_SAMPLE:   timing.read_sample_us = cfg_data;
				REG_READ_RECOVERY: timing.read_recovery_us = cfg_data;
				default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (bus_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, res);
					errs++;
				end else begin
					want = bus_results_q.pop_front();
					if (res.drive_low !== want.drive_low)
						flag("drive_low", 8'(want.drive_low), 8'(res.drive_low));
					if (res.busy_res !== want.busy_res)
						flag("busy_res", 8'(want.busy_res), 8'(res.busy_res));
					if (res.done_res !== want.done_res)
						flag("done_res", 8'(want.done_res), 8'(res.done_res));
					if (res.presence !== want.presence)
						flag("presence", 8'(want.presence), 8'(res.presence));
					if (res.read_data !== want.read_data)
						flag("read_data", want.read_data, res.read_data);
					if (res.rejected !== want.rejected)
						flag("rejected", 8'(want.rejected), 8'(res.rejected));
				end
			end
			if (cmd_valid && !cmd_stall)
				bus_results_q.push_back(bus_step(cmd));
			pending <= bus_results_q.size();
			fails <= errs;
		end
	end

endmodule

>>> test/one_wire_bus_master_core_tb.sv
// Testbench top for one_wire_bus_master_core: clock, reset, timing register writes,
// command/tick stimulus with idle and stall bursts, and the verdict.
// Depends on owbm_pkg, one_wire_bus_master_core and owbm_checker.
module one_wire_bus_master_core_tb;
	import owbm_pkg::*;

	localparam int CycleLimit = 2_000_000;

	localparam logic [2:0] FN_SPARE_A = 3'd6;
	localparam logic [2:0] FN_SPARE_B = 3'd7;

	localparam int SLAVE_ANSWERS = 0;
	localparam int SLAVE_NOISE   = 1;
	localparam int SLAVE_SILENT  = 2;
	localparam int SLAVE_STUCK   = 3;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	owbm_cmd_t          cmd;
	logic               res_valid;
	logic               res_stall;
	owbm_res_t          res;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	us_t                cfg_data;
	int                 fails;
	int                 pending;

	int        gap_pct = 0;
	int        stall_pct = 0;
	int        stall_left = 0;
	int        cycles = 0;
	int        done_cnt = 0;
	int        items = 0;
	owbm_cfg_t cur;

	one_wire_bus_master_core uut (.*);
	owbm_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("one_wire_bus_master_core_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(9);
			res_stall <= 1'b1;
		end else
			res_stall <= 1'b0;
		if (res_valid && !res_stall && res.done_res)
			done_cnt <= done_cnt + 1;
	end

	function automatic int hold(input us_t v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	function automatic us_t pick_us(input int hi);
		return ($urandom_range(4) == 0) ? us_t'(0) : us_t'($urandom_range(hi));
	endfunction

	function automatic owbm_cfg_t spread(input int hi);
		owbm_cfg_t t;
		t.reset_low_us        = pick_us(hi);
		t.presence_wait_us    = pick_us(hi);
		t.presence_timeout_us = pick_us(hi);
		t.release_timeout_us  = pick_us(hi);
		t.short_low_us        = pick_us(hi);
		t.long_low_us         = pick_us(hi);
		t.read_sample_us      = pick_us(hi);
		t.read_recovery_us    = pick_us(hi);
		return t;
	endfunction

	function automatic owbm_cfg_t flat(input us_t v);
		return owbm_cfg_t'({8{v}});
	endfunction

	task automatic send(input logic [2:0] fn, input logic [7:0] d, input logic lvl);
		owbm_cmd_t c;
		c.func = fn;
		c.data = d;
		c.line_level = lvl;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
	endtask

	// hold off until every item sent so far has its result back
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put(input logic [CfgIdxW-1:0] idx, input us_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_timing(input owbm_cfg_t t);
		settle();
		put(REG_RESET_LOW, t.reset_low_us);
		put(REG_PRES_WAIT, t.presence_wait_us);
		put(REG_PRES_TIMEOUT, t.presence_timeout_us);
		put(REG_REL_TIMEOUT, t.release_timeout_us);
		put(REG_SHORT_LOW, t.short_low_us);
		put(REG_LONG_LOW, t.long_low_us);
		put(REG_READ_SAMPLE, t.read_sample_us);
		put(REG_READ_RECOVERY, t.read_recovery_us);
		cfg_valid <= 1'b0;
		cur = t;
	endtask

	// one command, then ticks until its done item comes back; stray commands
	// sprinkled in while busy
	task automatic do_op(input logic [2:0] fn, input logic [7:0] d, input int mode,
			input int inj_pct);
		int seen;
		int n;
		int low_at;
		int high_at;
		logic lvl;
		seen = done_cnt;
		low_at = hold(cur.reset_low_us) + hold(cur.presence_wait_us)
			+ $urandom_range(int'(cur.presence_timeout_us) + 1, 1);
		high_at = low_at + $urandom_range(int'(cur.release_timeout_us) + 1, 1);
		send(fn, d, 1'($urandom));
		items++;
		n = 0;
		while (done_cnt == seen) begin
			if ($urandom_range(99) < inj_pct)
				send(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom));
			else begin
				n++;
				if (fn != FN_RESET || mode == SLAVE_NOISE)
					lvl = 1'($urandom);
				else if (mode == SLAVE_SILENT)
					lvl = 1'b1;
				else if (mode == SLAVE_STUCK)
					lvl = 1'b0;
				else
					lvl = (n < low_at || n >= high_at);
				send(FN_TICK, 8'($urandom), lvl);
			end
			items++;
		end
	endtask

	task automatic churn(input int goal, input int inj_pct);
		int stop;
		int pick;
		int mode;
		stop = items + goal;
		while (items < stop) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				send(FN_TICK, 8'($urandom), 1'($urandom));
				items++;
			end else if (pick < 6) begin
				send(($urandom_range(1) == 0) ? FN_SPARE_A : FN_SPARE_B,
					8'($urandom), 1'($urandom));
				items++;
			end else if (pick < 8 && gap_pct != 0)
				settle();
			else begin
				mode = $urandom_range(5);
				if (mode > SLAVE_STUCK)
					mode = SLAVE_ANSWERS;
				do_op(3'($urandom_range(5, 1)), 8'($urandom), mode, inj_pct);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		res_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RESET_LOW;
		cfg_data <= '0;
		cur = {10'd500, 10'd15, 10'd285, 10'd420, 10'd6, 10'd65, 10'd1, 10'd55};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// timing after reset
		do_op(FN_WR_BIT, 8'h01, SLAVE_NOISE, 0);
		do_op(FN_WR_BIT, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_RD_BIT, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_RESET, 8'h00, SLAVE_ANSWERS, 0);

		// directed: short timing, every command and bus response
		load_timing(flat(10'd2));
		do_op(FN_RESET, 8'h00, SLAVE_ANSWERS, 0);
		do_op(FN_RESET, 8'hFF, SLAVE_SILENT, 0);
		do_op(FN_RESET, 8'h00, SLAVE_STUCK, 0);
		do_op(FN_WR_BYTE, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_WR_BYTE, 8'hFF, SLAVE_NOISE, 0);
		do_op(FN_WR_BIT, 8'hFE, SLAVE_NOISE, 0);
		do_op(FN_WR_BIT, 8'h01, SLAVE_NOISE, 0);
		do_op(FN_RD_BYTE, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_RD_BIT, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_RD_BYTE, 8'h5A, SLAVE_NOISE, 40);
		send(FN_SPARE_A, 8'hFF, 1'b1);
		send(FN_SPARE_B, 8'h00, 1'b0);
		load_timing(flat(10'd0));
		do_op(FN_WR_BYTE, 8'hA5, SLAVE_NOISE, 0);
		do_op(FN_RD_BYTE, 8'h00, SLAVE_NOISE, 0);
		do_op(FN_RESET, 8'h00, SLAVE_ANSWERS, 0);
		do_op(FN_RD_BIT, 8'h00, SLAVE_NOISE, 20);

		// random timing, varying idle and stall pressure
		gap_pct = 0;
		stall_pct <= 0;
		load_timing(spread(3));
		churn(60, 3);
		gap_pct = 20;
		stall_pct <= 20;
		load_timing(spread(8));
		churn(60, 3);
		gap_pct = 40;
		stall_pct <= 40;
		load_timing(spread(15));
		churn(60, 3);
		gap_pct = 10;
		stall_pct <= 30;
		load_timing(spread(25));
		churn(60, 3);

		// closing stretch with no idling
		gap_pct = 0;
		stall_pct <= 0;
		load_timing(spread(6));
		churn(40, 3);

		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("one_wire_bus_master_core_tb OK");
		else
			$display("one_wire_bus_master_core_tb NOT OK");
		$finish;
	end

endmodule

>>> one_wire_bus_master_core.f
sv/owbm_pkg.sv
sv/owbm_cfg_regs.sv
sv/owbm_engine.sv
sv/one_wire_bus_master_core.sv
test/owbm_checker.sv
test/one_wire_bus_master_core_tb.sv
